// File: rtl/core/ses_pkg.sv
// ses_pkg: shared widths, register indexes, controller states and the
// command/status structs of the shell energy spectrum block.
// No dependencies.
package ses_pkg;

  // Field widths
  localparam int WAVE_W     = 32;
  localparam int COMP_W     = 16;
  localparam int INV_W      = 32;
  localparam int NS_W       = 7;
  localparam int ACC_W      = 48;
  localparam int IDX_OUT_W  = 6;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // Square root of the norm taken as a 48-bit radicand, one root bit a cycle
  localparam int RAD_W      = 48;
  localparam int ROOT_W     = 24;
  localparam int REM_W      = ROOT_W + 3;
  localparam int ROOT_ITERS = ROOT_W;
  localparam int CNT_W      = $clog2(ROOT_ITERS);
  localparam int PROD_W     = ROOT_W + INV_W;
  localparam int SHELL_W    = PROD_W - 32;

  // Sum of two or six squares of Q1.15 parts, Q3.30
  localparam int SQ_W       = 2 * COMP_W;
  localparam int TERM_W     = SQ_W + 1;
  localparam int NUM_COMP   = 6;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_SHELLS  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INV_STEP    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_VECTOR_MODE = 2'd2;

  localparam logic [NS_W-1:0]  RST_NUM_SHELLS = 7'd32;
  localparam logic [INV_W-1:0] RST_INV_STEP   = 32'd65536;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_MUL,
    S_READ,
    S_ADD,
    S_EMIT_RD,
    S_EMIT_LD
  } ses_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept_en;
    logic root_step;
    logic mul;
    logic bin_rd;
    logic bin_wr;
    logic emit_rd;
    logic emit_ld;
  } ses_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_fire;
    logic root_done;
    logic item_last;
    logic out_free;
    logic emit_last;
  } ses_sts_t;

endpackage

// File: rtl/core/ses_in_if.sv
// ses_in_if: input channel, one spectral coefficient per word.
// Depends on ses_pkg.
interface ses_in_if import ses_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [WAVE_W-1:0]        wave_sq;
  logic signed [COMP_W-1:0] re_a;
  logic signed [COMP_W-1:0] im_a;
  logic signed [COMP_W-1:0] re_b;
  logic signed [COMP_W-1:0] im_b;
  logic signed [COMP_W-1:0] re_c;
  logic signed [COMP_W-1:0] im_c;
  logic                     last_item;

  modport source (output valid, wave_sq, re_a, im_a, re_b, im_b, re_c, im_c, last_item,
                  input ready);
  modport sink   (input valid, wave_sq, re_a, im_a, re_b, im_b, re_c, im_c, last_item,
                  output ready);
endinterface

// File: rtl/core/ses_out_if.sv
// ses_out_if: result channel, one shell energy per word.
// Depends on ses_pkg.
interface ses_out_if import ses_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] shell_index;
  logic [ACC_W-1:0]     shell_energy;
  logic                 last_shell;

  modport source (output valid, shell_index, shell_energy, last_shell, input ready);
  modport sink   (input valid, shell_index, shell_energy, last_shell, output ready);
endinterface

// File: rtl/core/ses_ctrl.sv
// ses_ctrl: sequencer of the shell energy spectrum block.
// Depends on ses_pkg; drives ses_datapath through ses_cmd_t, reads ses_sts_t.
module ses_ctrl import ses_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ses_sts_t sts,
  output ses_cmd_t cmd
);

  ses_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept_en = 1'b1;
        if (sts.in_fire) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.bin_rd = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        cmd.bin_wr = 1'b1;
        state_nxt  = sts.item_last ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        // wait until the output register is free or being taken
        if (sts.out_free) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_nxt   = sts.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/ses_datapath.sv
// ses_datapath: configuration registers, bit-serial square root, shell
// multiplier, energy accumulator, bin memory and output register.
// Depends on ses_pkg, ses_in_if and ses_out_if; commanded by ses_ctrl.
module ses_datapath import ses_pkg::*; #(
  parameter int MAX_SHELLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ses_in_if.sink                in_ch,
  ses_out_if.source             out_ch,
  input  ses_cmd_t              cmd,
  output ses_sts_t              sts
);

  localparam int IDX_W = $clog2(MAX_SHELLS);

  // Configuration
  logic [NS_W-1:0]  num_shells_r;
  logic [INV_W-1:0] inv_step_r;
  logic             vector_mode_r;

  // Item registers
  logic [RAD_W-1:0]         rad_r;
  logic [REM_W-1:0]         rem_r;
  logic [ROOT_W-1:0]        root_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [TERM_W-1:0]        term_r;
  logic signed [COMP_W-1:0] comp_r [NUM_COMP];
  logic                     last_r;
  logic [PROD_W-1:0]        prod_r;
  logic [IDX_W-1:0]         addr_r;

  // Bin store
  logic [ACC_W-1:0]      bin_mem [MAX_SHELLS];
  logic [MAX_SHELLS-1:0] vld_r;
  logic [ACC_W-1:0]      rd_data_r;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_addr;
  logic [ACC_W-1:0]      old_bin;
  logic [ACC_W:0]        sum;
  logic [ACC_W-1:0]      sat_bin;

  // Emission
  logic [IDX_W-1:0]     ek_r;
  logic                 out_valid_r;
  logic [IDX_OUT_W-1:0] out_index_r;
  logic [ACC_W-1:0]     out_energy_r;
  logic                 out_last_r;

  // Combinational helpers
  logic                     in_fire;
  logic [NS_W-1:0]          n_eff;
  logic [NS_W-1:0]          top_shell;
  logic [SHELL_W-1:0]       shell_raw;
  logic [IDX_W-1:0]         shell_sel;
  logic [REM_W-1:0]         rem_sh;
  logic [REM_W-1:0]         trial;
  logic signed [COMP_W-1:0] comp_cur;
  logic signed [SQ_W-1:0]   sq;
  logic                     comp_use;
  logic                     emit_last;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = cmd.accept_en;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_shells_r  <= RST_NUM_SHELLS;
      inv_step_r    <= RST_INV_STEP;
      vector_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NUM_SHELLS:  num_shells_r  <= cfg_wdata[NS_W-1:0];
        REG_INV_STEP:    inv_step_r    <= cfg_wdata[INV_W-1:0];
        REG_VECTOR_MODE: vector_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Shells in use: zero acts as one, past the store acts as the store size
  always_comb begin
    priority if (num_shells_r == '0) begin
      n_eff = NS_W'(1);
    end else if (num_shells_r > NS_W'(MAX_SHELLS)) begin
      n_eff = NS_W'(MAX_SHELLS);
    end else begin
      n_eff = num_shells_r;
    end
  end
  assign top_shell = n_eff - NS_W'(1);

  // One restoring square root step
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});

  // Component squared this cycle
  assign comp_cur = comp_r[cnt_r[2:0]];
  assign sq       = comp_cur * comp_cur;
  assign comp_use = (cnt_r < CNT_W'(2)) || (vector_mode_r && (cnt_r < CNT_W'(NUM_COMP)));

  // Load the item, then iterate root and energy term
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rad_r     <= {in_ch.wave_sq, {(RAD_W-WAVE_W){1'b0}}};
      rem_r     <= '0;
      root_r    <= '0;
      term_r    <= '0;
      comp_r[0] <= in_ch.re_a;
      comp_r[1] <= in_ch.im_a;
      comp_r[2] <= in_ch.re_b;
      comp_r[3] <= in_ch.im_b;
      comp_r[4] <= in_ch.re_c;
      comp_r[5] <= in_ch.im_c;
      last_r    <= in_ch.last_item;
    end else if (cmd.root_step) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
      if (comp_use) term_r <= term_r + TERM_W'($unsigned(sq));
    end
  end

  // Iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_fire) begin
      cnt_r <= '0;
    end else if (cmd.root_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Scale root by reciprocal shell width
  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= PROD_W'(root_r) * PROD_W'(inv_step_r);
  end

  // Clamp shell into the last shell in use
  assign shell_raw = prod_r[PROD_W-1 -: SHELL_W];
  always_comb begin
    if (shell_raw > SHELL_W'(top_shell)) begin
      shell_sel = top_shell[IDX_W-1:0];
    end else begin
      shell_sel = shell_raw[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bin_rd) addr_r <= shell_sel;
  end

  // Bin memory: registered read, single write port
  assign rd_addr = cmd.emit_rd ? ek_r : shell_sel;

  always_ff @(posedge clk) begin
    rd_data_r <= bin_mem[rd_addr];
    if (cmd.bin_wr) bin_mem[addr_r] <= sat_bin;
  end

  // Saturating accumulate; a bin not written since the last clear reads zero
  assign old_bin = rd_vld_r ? rd_data_r : '0;
  assign sum     = {1'b0, old_bin} + (ACC_W+1)'(term_r);
  assign sat_bin = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];

  assign emit_last = ({1'b0, ek_r} >= (IDX_W+1)'(top_shell));

  // Valid bits and emission counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      ek_r     <= '0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
      if (cmd.bin_wr) vld_r[addr_r] <= 1'b1;
      if (cmd.emit_ld) begin
        if (emit_last) begin
          vld_r <= '0;
          ek_r  <= '0;
        end else begin
          ek_r <= ek_r + IDX_W'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_index_r  <= IDX_OUT_W'(ek_r);
      out_energy_r <= old_bin;
      out_last_r   <= emit_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.shell_index  = out_index_r;
  assign out_ch.shell_energy = out_energy_r;
  assign out_ch.last_shell   = out_last_r;

  // Status
  assign sts.in_fire   = in_fire;
  assign sts.root_done = (cnt_r == CNT_W'(ROOT_ITERS - 1));
  assign sts.item_last = last_r;
  assign sts.out_free  = !out_valid_r || out_ch.ready;
  assign sts.emit_last = emit_last;

  // Never overwrite a result still waiting at the output
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ld |-> !out_valid_r)
    else $error("output register loaded while occupied");

  // Store fully cleared once a spectrum has been emitted
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_ld && emit_last) |=> (vld_r == '0))
    else $error("bins not cleared after emission");

  // A new item starts only with the emission counter at rest
  a_ek_rest: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (ek_r == '0))
    else $error("item accepted with emission in progress");

  // Accumulation never loses energy
  a_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bin_wr |-> (sat_bin >= old_bin))
    else $error("bin accumulate decreased");

endmodule

// File: rtl/core/shell_energy_spectrum.sv
// Flow: an accepted word passes through the 24 root steps of the bit-serial
// square root, the multiply, the bin read and the bin write before the next
// word is taken. On a last word each shell result is read in turn from the
// registered bin memory and loaded into the output register as it is taken.
// Reset: synchronous active-low rst_n clears control, bin valid bits and loads
// register defaults (32 shells, unit reciprocal width, scalar mode).
module shell_energy_spectrum import ses_pkg::*; #(
  parameter int MAX_SHELLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ses_in_if.sink                in_ch,
  ses_out_if.source             out_ch
);

  ses_cmd_t cmd;
  ses_sts_t sts;

  // Sequencer
  ses_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Arithmetic and bin store
  ses_datapath #(
    .MAX_SHELLS (MAX_SHELLS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: tb/tb_shell_energy_spectrum.sv
// tb_shell_energy_spectrum: self-checking bench for the radial shell energy histogram.
// It drives coefficient words and register writes, predicts every shell energy and checks it.
// Depends on ses_pkg, ses_in_if, ses_out_if and shell_energy_spectrum.
module tb_shell_energy_spectrum import ses_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int MAX_SH         = 64;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SEG_WORDS      = 26;
  localparam int FULL_WORDS     = 4;

  typedef struct packed {
    logic [WAVE_W-1:0] wave_sq;
    logic [COMP_W-1:0] re_a;
    logic [COMP_W-1:0] im_a;
    logic [COMP_W-1:0] re_b;
    logic [COMP_W-1:0] im_b;
    logic [COMP_W-1:0] re_c;
    logic [COMP_W-1:0] im_c;
    logic              last_item;
  } spectral_coef_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] shell_index;
    logic [ACC_W-1:0]     shell_energy;
    logic                 last_shell;
  } shell_result_t;

  // Shell histogram predictor and the queue of shell energies still owed by the block
  class spectrum_checker;
    logic [ACC_W-1:0] energy_bins [MAX_SH];
    logic [NS_W-1:0]  num_shells;
    logic [INV_W-1:0] inv_step;
    logic             vector_mode;
    shell_result_t    expected_shells [$];
    int unsigned      mismatches;

    function new();
      num_shells  = RST_NUM_SHELLS;
      inv_step    = RST_INV_STEP;
      vector_mode = 1'b0;
      mismatches  = 0;
      foreach (energy_bins[k]) energy_bins[k] = '0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_NUM_SHELLS:  num_shells  = data[NS_W-1:0];
        REG_INV_STEP:    inv_step    = data[INV_W-1:0];
        REG_VECTOR_MODE: vector_mode = data[0];
        default: ;
      endcase
    endfunction

    // Zero behaves as one shell, anything past the store behaves as a full store
    function int unsigned shells_active();
      if (num_shells == 0) return 1;
      if (num_shells > MAX_SH) return MAX_SH;
      return num_shells;
    endfunction

    // Truncated square root of the norm in Q8.16, settled one root bit at a time
    function longint unsigned norm_root(logic [WAVE_W-1:0] wave);
      longint unsigned radicand;
      longint unsigned root;
      longint unsigned trial;
      radicand = {16'h0, wave, 16'h0};
      root = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= radicand) root = trial;
      end
      return root;
    endfunction

    function longint unsigned part_sq(logic [COMP_W-1:0] part);
      longint s;
      s = $signed(part);
      return s * s;
    endfunction

    function void take_coef(spectral_coef_t c);
      longint unsigned shell;
      longint unsigned energy;
      longint unsigned total;
      int unsigned     n;
      shell_result_t   r;
      n = shells_active();
      shell = (norm_root(c.wave_sq) * inv_step) >> 32;
      if (shell > n - 1) shell = n - 1;
      energy = part_sq(c.re_a) + part_sq(c.im_a);
      if (vector_mode)
        energy += part_sq(c.re_b) + part_sq(c.im_b) + part_sq(c.re_c) + part_sq(c.im_c);
      // Saturate the bin at full scale
      total = energy_bins[shell] + energy;
      energy_bins[shell] = (total > ACC_MAX) ? ACC_MAX : total[ACC_W-1:0];
      if (c.last_item) begin
        for (int k = 0; k < n; k++) begin
          r.shell_index  = IDX_OUT_W'(k);
          r.shell_energy = energy_bins[k];
          r.last_shell   = (k == n - 1);
          expected_shells.push_back(r);
        end
        // Clear the whole store, shells past the current count too
        foreach (energy_bins[k]) energy_bins[k] = '0;
      end
    endfunction

    function void check_shell(shell_result_t got);
      shell_result_t want;
      if (expected_shells.size() == 0) begin
        $display("%0t: unexpected shell word, expected none, actual index %0d energy %0h",
                 $time, got.shell_index, got.shell_energy);
        mismatches++;
        return;
      end
      want = expected_shells.pop_front();
      if (got.shell_index !== want.shell_index) begin
        $display("%0t: shell_index expected %0d actual %0d",
                 $time, want.shell_index, got.shell_index);
        mismatches++;
      end
      if (got.shell_energy !== want.shell_energy) begin
        $display("%0t: shell_energy of shell %0d expected %0h actual %0h",
                 $time, want.shell_index, want.shell_energy, got.shell_energy);
        mismatches++;
      end
      if (got.last_shell !== want.last_shell) begin
        $display("%0t: last_shell of shell %0d expected %0b actual %0b",
                 $time, want.shell_index, want.last_shell, got.last_shell);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ses_in_if  in_ch ();
  ses_out_if out_ch ();

  spectrum_checker sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_start    = 1'b0;
  int unsigned quiet_cycles  = 0;

  shell_energy_spectrum #(.MAX_SHELLS(MAX_SH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side: random back-pressure, with a long hold-off when requested
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every shell word taken from the block
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_shell('{out_ch.shell_index, out_ch.shell_energy, out_ch.last_shell});
  end

  // Abort when no word moves on either channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("FAIL shell_energy_spectrum");
        $finish;
      end
    end
  end

  // Offer one coefficient word; enter and leave at a falling edge
  task automatic send_word(input spectral_coef_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.wave_sq   <= c.wave_sq;
    in_ch.re_a      <= c.re_a;
    in_ch.im_a      <= c.im_a;
    in_ch.re_b      <= c.re_b;
    in_ch.im_b      <= c.im_b;
    in_ch.re_c      <= c.re_c;
    in_ch.im_c      <= c.im_c;
    in_ch.last_item <= c.last_item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_coef(c);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed shell word, then let the pipeline empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_shells.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(addr, data);
    @(negedge clk);
  endtask

  function automatic spectral_coef_t make_coef(
      logic [WAVE_W-1:0] wave, logic [COMP_W-1:0] ra, logic [COMP_W-1:0] ia,
      logic [COMP_W-1:0] rb, logic [COMP_W-1:0] ib, logic [COMP_W-1:0] rc,
      logic [COMP_W-1:0] ic, logic last);
    return '{wave, ra, ia, rb, ib, rc, ic, last};
  endfunction

  function automatic logic [COMP_W-1:0] random_part();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  function automatic spectral_coef_t random_coef(logic last);
    spectral_coef_t c;
    int unsigned    k;
    case ($urandom_range(3))
      0:       c.wave_sq = $urandom;
      1:       c.wave_sq = $urandom >> $urandom_range(31);
      default: begin
        // Land on or just below a whole radius
        k = $urandom_range(70);
        c.wave_sq = ((k * k) << 16) - $urandom_range(1);
      end
    endcase
    c.re_a      = random_part();
    c.im_a      = random_part();
    c.re_b      = random_part();
    c.im_b      = random_part();
    c.re_c      = random_part();
    c.im_c      = random_part();
    c.last_item = last;
    return c;
  endfunction

  task automatic random_frame(input int unsigned len);
    for (int i = 0; i < len; i++) send_word(random_coef(i == len - 1));
  endtask

  // Pick a new register setting, with junk above the used bits
  task automatic random_config();
    logic [CFG_DATA_W-1:0] ns_word;
    logic [INV_W-1:0]      step;
    ns_word = $urandom;
    case ($urandom_range(5))
      0:       ns_word[NS_W-1:0] = 7'd1;
      1:       ns_word[NS_W-1:0] = 7'd64;
      2:       ns_word[NS_W-1:0] = NS_W'($urandom_range(65, 127));
      3:       ns_word[NS_W-1:0] = 7'd0;
      default: ns_word[NS_W-1:0] = NS_W'($urandom_range(2, 63));
    endcase
    case ($urandom_range(5))
      0:       step = '0;
      1:       step = '1;
      2:       step = RST_INV_STEP;
      3:       step = $urandom;
      default: step = $urandom_range(32'h1000, 32'h40000);
    endcase
    write_reg(REG_NUM_SHELLS, ns_word);
    write_reg(REG_INV_STEP, step);
    write_reg(REG_VECTOR_MODE, $urandom);
  endtask

  initial begin : stimulus
    int unsigned len;
    int unsigned sent;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.wave_sq   = '0;
    in_ch.re_a      = '0;
    in_ch.im_a      = '0;
    in_ch.re_b      = '0;
    in_ch.im_b      = '0;
    in_ch.re_c      = '0;
    in_ch.im_c      = '0;
    in_ch.last_item = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: scalar mode ignores b and c, far norm clamps to the last shell
    send_word(make_coef('0, '0, '0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
    send_word(make_coef('1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, '0, '0, 1'b0));
    send_word(make_coef(32'h0001_0000, 16'h7FFF, 16'hFFFF, '0, '0, '0, '0, 1'b1));
    drain();

    // Zero shell count acts as one, widest reciprocal, vector mode
    write_reg(REG_NUM_SHELLS, 32'd0);
    write_reg(REG_INV_STEP, '1);
    write_reg(REG_VECTOR_MODE, 32'd1);
    send_word(make_coef(32'h0001_0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                        16'h8000, 16'h8000, 1'b0));
    send_word(make_coef($urandom, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                        16'h7FFF, 16'h7FFF, 1'b1));
    drain();

    // Oversized shell count acts as full store, zero reciprocal lands all in shell 0
    write_reg(REG_NUM_SHELLS, 32'd127);
    write_reg(REG_INV_STEP, '0);
    send_word(make_coef('1, 16'h1234, 16'hEDCB, 16'h0001, 16'hFFFF, 16'h4000, 16'hC000, 1'b0));
    send_word(make_coef('0, 16'h7FFF, 16'h8000, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 1'b1));
    drain();

    // Unit width: radius truncation, top shell, clamp past it, and a far shell left over
    write_reg(REG_NUM_SHELLS, 32'd64);
    write_reg(REG_INV_STEP, RST_INV_STEP);
    send_word(make_coef((32'd25 << 16) - 1, 16'h0100, '0, '0, '0, '0, 16'h0200, 1'b0));
    send_word(make_coef(32'd25 << 16, 16'h0300, '0, '0, 16'h0400, '0, '0, 1'b0));
    send_word(make_coef(32'd3969 << 16, 16'h0500, '0, 16'h0600, '0, '0, '0, 1'b0));
    send_word(make_coef(32'd4096 << 16, '0, 16'h0700, '0, '0, 16'h0800, '0, 1'b0));
    send_word(make_coef(32'd2500 << 16, 16'h0900, 16'h0A00, '0, '0, '0, '0, 1'b0));
    drain();

    // Shrink the count mid-field: only four shells come out, the rest still clears
    write_reg(REG_NUM_SHELLS, 32'd4);
    write_reg(REG_VECTOR_MODE, 32'd0);
    send_word(make_coef(32'd2 << 16, 16'h0B00, 16'h0C00, '0, '0, '0, '0, 1'b1));
    drain();
    write_reg(REG_NUM_SHELLS, 32'd64);
    send_word(make_coef('0, 16'h0001, 16'h0001, '0, '0, '0, '0, 1'b1));
    drain();

    // Random fields under changing settings and idling mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        random_config();
        if (phase == 0 && seg == 1) begin
          // Hold off the result side so the block backs up onto its input
          @(posedge clk);
          hold_start = 1'b1;
          @(negedge clk);
          random_frame(2);
        end
        sent = 0;
        while (sent < SEG_WORDS) begin
          len = $urandom_range(1, 8);
          random_frame(len);
          sent = sent + len;
        end
        drain();
      end
    end

    // Pile full-scale vector words into one bin
    write_reg(REG_NUM_SHELLS, 32'd1);
    write_reg(REG_INV_STEP, '0);
    write_reg(REG_VECTOR_MODE, 32'd1);
    for (int i = 0; i < FULL_WORDS; i++)
      send_word(make_coef($urandom, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, i == FULL_WORDS - 1));
    drain();
    random_frame(3);
    drain();

    if (sb.mismatches == 0 && sb.expected_shells.size() == 0)
      $display("PASS shell_energy_spectrum");
    else
      $display("FAIL shell_energy_spectrum");
    $finish;
  end

endmodule

// File: shell_energy_spectrum.f
rtl/core/ses_pkg.sv
rtl/core/ses_in_if.sv
rtl/core/ses_out_if.sv
rtl/core/ses_ctrl.sv
rtl/core/ses_datapath.sv
rtl/core/shell_energy_spectrum.sv
tb/tb_shell_energy_spectrum.sv
